/* src/sms_pkg.sv */
// Shared types and constants for the SPI master shift engine.
package sms_pkg;

	localparam int TX_WIDTH       = 32;
	localparam int RX_WIDTH       = 32;
	localparam int HALF_WIDTH     = 16;
	localparam int WBITS_WIDTH    = 6;
	localparam int CFG_ADDR_WIDTH = 4;
	localparam int CFG_DATA_WIDTH = 32;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_HALF_PERIOD = 2'd0,
		REG_CLOCK_POL   = 2'd1,
		REG_CLOCK_PHASE = 2'd2,
		REG_WORD_BITS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [HALF_WIDTH-1:0]  half_period_ticks;
		logic                   clock_polarity;
		logic                   clock_phase;
		logic [WBITS_WIDTH-1:0] word_bits;
	} cfg_t;

	typedef struct packed {
		logic                opcode;
		logic [TX_WIDTH-1:0] tx_word;
		logic                select_before;
		logic                release_after;
		logic                miso;
	} item_t;

	typedef struct packed {
		logic                sck;
		logic                mosi;
		logic                cs_active;
		logic [RX_WIDTH-1:0] rx_word;
		logic                rx_valid;
		logic                busy_res;
		logic                rejected;
	} result_t;

endpackage

/* src/sms_apb.sv */
// APB configuration registers for the SPI master shift engine.
module sms_apb import sms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_WIDTH'(1);
			cfg_q.clock_polarity    <= 1'b0;
			cfg_q.clock_phase       <= 1'b0;
			cfg_q.word_bits         <= WBITS_WIDTH'(8);
		end else if (wr_en) begin
			unique case (idx)
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= pwdata[HALF_WIDTH-1:0];
				REG_CLOCK_POL:   cfg_q.clock_polarity    <= pwdata[0];
				REG_CLOCK_PHASE: cfg_q.clock_phase       <= pwdata[0];
				REG_WORD_BITS:   cfg_q.word_bits         <= pwdata[WBITS_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_HALF_PERIOD: prdata = CFG_DATA_WIDTH'(cfg_q.half_period_ticks);
			REG_CLOCK_POL:   prdata = CFG_DATA_WIDTH'(cfg_q.clock_polarity);
			REG_CLOCK_PHASE: prdata = CFG_DATA_WIDTH'(cfg_q.clock_phase);
			REG_WORD_BITS:   prdata = CFG_DATA_WIDTH'(cfg_q.word_bits);
			default:         prdata = '0;
		endcase
	end

endmodule

/* src/sms_core.sv */
// Transfer state and per-item next-state logic of the SPI master shift engine.
module sms_core import sms_pkg::*; #(
	parameter int MAX_WORD_BITS    = 32,
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int BL_W   = $clog2(MAX_WORD_BITS + 1);
	localparam int EXT_W  = (MAX_WORD_BITS > TX_WIDTH) ? MAX_WORD_BITS : TX_WIDTH;
	localparam int SH_W   = $clog2(EXT_W + 1);
	localparam int NB_W   = (BL_W > WBITS_WIDTH) ? BL_W : WBITS_WIDTH;
	localparam int HCMP_W = ((TICK_COUNT_WIDTH > HALF_WIDTH) ? TICK_COUNT_WIDTH : HALF_WIDTH) + 1;

	logic [MAX_WORD_BITS-1:0]    shift_q, shift_n;
	logic [BL_W-1:0]             bits_left_q, bits_left_n;
	logic [TICK_COUNT_WIDTH-1:0] tick_q, tick_n;
	logic                        second_half_q, second_half_n;
	logic                        active_q, active_n;
	logic                        select_q, select_n;
	logic                        release_q, release_n;
	logic                        clock_q, clock_n;
	logic                        data_q, data_n;

	logic [NB_W-1:0]             wb_ext;
	logic [BL_W-1:0]             n_eff;
	logic [HCMP_W-1:0]           half_ext;
	logic [TICK_COUNT_WIDTH-1:0] half_eff;
	logic [TICK_COUNT_WIDTH:0]   tick_inc;
	logic                        half_done;
	logic [EXT_W-1:0]            tx_shifted;
	logic [MAX_WORD_BITS-1:0]    load_val;
	logic [MAX_WORD_BITS-1:0]    shift_in;
	logic [EXT_W-1:0]            shift_in_ext;
	logic                        rejected, rx_valid;
	logic [RX_WIDTH-1:0]         rx_word;

	// effective word length: zero means one bit, saturate at the shift register size
	always_comb begin
		wb_ext = NB_W'(cfg.word_bits);
		if (wb_ext == '0) begin
			n_eff = BL_W'(1);
		end else if (wb_ext > NB_W'(MAX_WORD_BITS)) begin
			n_eff = BL_W'(MAX_WORD_BITS);
		end else begin
			n_eff = wb_ext[BL_W-1:0];
		end
	end

	// effective half period: zero means one tick, saturate at the counter maximum
	always_comb begin
		half_ext = HCMP_W'(cfg.half_period_ticks);
		if (half_ext == '0) begin
			half_eff = TICK_COUNT_WIDTH'(1);
		end else if (half_ext > HCMP_W'({TICK_COUNT_WIDTH{1'b1}})) begin
			half_eff = {TICK_COUNT_WIDTH{1'b1}};
		end else begin
			half_eff = half_ext[TICK_COUNT_WIDTH-1:0];
		end
	end

	assign tick_inc  = {1'b0, tick_q} + (TICK_COUNT_WIDTH+1)'(1);
	assign half_done = tick_inc >= {1'b0, half_eff};

	// left-justify the low n bits of the word
	assign tx_shifted   = EXT_W'(item.tx_word) << (SH_W'(EXT_W) - SH_W'(n_eff));
	assign load_val     = tx_shifted[EXT_W-1 -: MAX_WORD_BITS];
	assign shift_in     = {shift_q[MAX_WORD_BITS-2:0], item.miso};
	assign shift_in_ext = EXT_W'(shift_in);

	always_comb begin
		shift_n       = shift_q;
		bits_left_n   = bits_left_q;
		tick_n        = tick_q;
		second_half_n = second_half_q;
		active_n      = active_q;
		select_n      = select_q;
		release_n     = release_q;
		clock_n       = clock_q;
		data_n        = data_q;
		rejected      = 1'b0;
		rx_valid      = 1'b0;
		rx_word       = '0;
		if (item.opcode == OP_START) begin
			if (active_q) begin
				rejected = 1'b1;
			end else begin
				if (item.select_before) begin
					select_n = 1'b1;
				end
				release_n     = item.release_after;
				shift_n       = load_val;
				bits_left_n   = n_eff;
				tick_n        = '0;
				second_half_n = 1'b0;
				active_n      = 1'b1;
				clock_n       = cfg.clock_phase ? ~cfg.clock_polarity : cfg.clock_polarity;
				data_n        = load_val[MAX_WORD_BITS-1];
			end
		end else if (active_q) begin
			if (half_done) begin
				tick_n = '0;
				if (!second_half_q) begin
					clock_n       = cfg.clock_phase ? cfg.clock_polarity : ~cfg.clock_polarity;
					second_half_n = 1'b1;
				end else begin
					shift_n       = shift_in;
					bits_left_n   = bits_left_q - BL_W'(1);
					second_half_n = 1'b0;
					clock_n       = cfg.clock_polarity;
					if (bits_left_q == BL_W'(1)) begin
						active_n = 1'b0;
						rx_valid = 1'b1;
						rx_word  = shift_in_ext[RX_WIDTH-1:0];
						if (release_q) begin
							select_n  = 1'b0;
							release_n = 1'b0;
						end
					end else begin
						if (cfg.clock_phase) begin
							clock_n = ~cfg.clock_polarity;
						end
						data_n = shift_in[MAX_WORD_BITS-1];
					end
				end
			end else begin
				tick_n = tick_inc[TICK_COUNT_WIDTH-1:0];
			end
		end
		// idle clock follows polarity
		if (!active_n) begin
			clock_n = cfg.clock_polarity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q       <= '0;
			bits_left_q   <= '0;
			tick_q        <= '0;
			second_half_q <= 1'b0;
			active_q      <= 1'b0;
			select_q      <= 1'b0;
			release_q     <= 1'b0;
			clock_q       <= 1'b0;
			data_q        <= 1'b0;
		end else if (step) begin
			shift_q       <= shift_n;
			bits_left_q   <= bits_left_n;
			tick_q        <= tick_n;
			second_half_q <= second_half_n;
			active_q      <= active_n;
			select_q      <= select_n;
			release_q     <= release_n;
			clock_q       <= clock_n;
			data_q        <= data_n;
		end
	end

	always_comb begin
		result.sck       = clock_n;
		result.mosi      = data_n;
		result.cs_active = select_n;
		result.rx_word   = rx_word;
		result.rx_valid  = rx_valid;
		result.busy_res  = active_n;
		result.rejected  = rejected;
	end

endmodule

/* src/spi_master_shift_engine_top.sv */
// Top level of the SPI master shift engine: APB registers, item register, core and result register.
//
//  channel  direction  handshake               payload
//  in       to block   in_valid / in_ready     opcode tx_word select_before release_after miso
//  out      from block out_valid / out_ready   sck mosi cs_active rx_word rx_valid busy_res rejected
//  cfg      to block   APB psel/penable/pready paddr pwdata prdata
//
// One item per cycle sustained while out_ready is high; an accepted item goes to the item register,
// then the result register (the core updates its state between them).
// Reset is asynchronous and clears transfer state and both valid flags.
// A stalled result holds the item register; in_ready is low only while both registers
// are full and out_ready is low.
module spi_master_shift_engine_top import sms_pkg::*; #(
	parameter int MAX_WORD_BITS    = 32,
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [TX_WIDTH-1:0]       tx_word,
	input  logic                      select_before,
	input  logic                      release_after,
	input  logic                      miso,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      sck,
	output logic                      mosi,
	output logic                      cs_active,
	output logic [RX_WIDTH-1:0]       rx_word,
	output logic                      rx_valid,
	output logic                      busy_res,
	output logic                      rejected,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t core_result;
	logic    fire;

	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;

	sms_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode        <= opcode;
			item_s1.tx_word       <= tx_word;
			item_s1.select_before <= select_before;
			item_s1.release_after <= release_after;
			item_s1.miso          <= miso;
		end
	end

	sms_core #(
		.MAX_WORD_BITS    (MAX_WORD_BITS),
		.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid = valid_s2;
	assign sck       = result_s2.sck;
	assign mosi      = result_s2.mosi;
	assign cs_active = result_s2.cs_active;
	assign rx_word   = result_s2.rx_word;
	assign rx_valid  = result_s2.rx_valid;
	assign busy_res  = result_s2.busy_res;
	assign rejected  = result_s2.rejected;

endmodule

/* dv/tb_spi_master_shift_engine_top.sv */
// Testbench for the SPI master shift engine: item driver, pin-level predictor and result checker.
`timescale 1ns / 1ps

module tb_spi_master_shift_engine_top;
	import sms_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      opcode;
	logic [TX_WIDTH-1:0]       tx_word;
	logic                      select_before;
	logic                      release_after;
	logic                      miso;
	logic                      out_valid;
	logic                      out_ready;
	logic                      sck;
	logic                      mosi;
	logic                      cs_active;
	logic [RX_WIDTH-1:0]       rx_word;
	logic                      rx_valid;
	logic                      busy_res;
	logic                      rejected;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [CFG_ADDR_WIDTH-1:0] paddr;
	logic [CFG_DATA_WIDTH-1:0] pwdata;
	logic [CFG_DATA_WIDTH-1:0] prdata;
	logic                      pready;

	spi_master_shift_engine_top i_dut (.*);

	class spi_pin_scoreboard;
		logic [HALF_WIDTH-1:0]  half_reg;
		logic [WBITS_WIDTH-1:0] wbits_reg;
		bit                     cpol;
		bit                     cpha;

		logic [31:0] shifter;
		int unsigned bits_togo;
		int unsigned tick_cnt;
		bit          in_second;
		bit          xfer_on;
		bit          cs_lvl;
		bit          rel_armed;
		bit          sck_lvl;
		bit          mosi_lvl;

		result_t pins_due[$];
		int      mismatches;
		int      n_checked;

		function new();
			half_reg   = 1;
			wbits_reg  = 8;
			cpol       = 0;
			cpha       = 0;
			shifter    = '0;
			bits_togo  = 0;
			tick_cnt   = 0;
			in_second  = 0;
			xfer_on    = 0;
			cs_lvl     = 0;
			rel_armed  = 0;
			sck_lvl    = 0;
			mosi_lvl   = 0;
			mismatches = 0;
			n_checked  = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_HALF_PERIOD: half_reg = val[HALF_WIDTH-1:0];
				REG_CLOCK_POL: cpol = val[0];
				REG_CLOCK_PHASE: cpha = val[0];
				REG_WORD_BITS: wbits_reg = val[WBITS_WIDTH-1:0];
			endcase
		endfunction

		function int unsigned word_len();
			int unsigned n;
			n = wbits_reg;
			if (n == 0) n = 1;
			if (n > 32) n = 32;
			return n;
		endfunction

		function int unsigned half_len();
			return (half_reg == 0) ? 1 : half_reg;
		endfunction

		function void accept_item(item_t it);
			result_t     due;
			logic [63:0] loaded;
			int unsigned n;
			due = '0;
			if (it.opcode == OP_START) begin
				if (xfer_on) begin
					due.rejected = 1'b1;
				end else begin
					n = word_len();
					if (it.select_before) cs_lvl = 1;
					rel_armed = it.release_after;
					loaded    = ({32'h0, it.tx_word} & ((64'h1 << n) - 64'h1)) << (32 - n);
					shifter   = loaded[31:0];
					bits_togo = n;
					tick_cnt  = 0;
					in_second = 0;
					xfer_on   = 1;
					sck_lvl   = cpha ? ~cpol : cpol;
					mosi_lvl  = shifter[31];
				end
			end else if (xfer_on) begin
				tick_cnt++;
				if (tick_cnt >= half_len()) begin
					tick_cnt = 0;
					if (!in_second) begin
						sck_lvl   = cpha ? cpol : ~cpol;
						in_second = 1;
					end else begin
						shifter   = {shifter[30:0], it.miso};
						bits_togo--;
						in_second = 0;
						sck_lvl   = cpol;
						if (bits_togo == 0) begin
							xfer_on      = 0;
							due.rx_valid = 1'b1;
							due.rx_word  = shifter;
							if (rel_armed) begin
								cs_lvl    = 0;
								rel_armed = 0;
							end
						end else begin
							if (cpha) sck_lvl = ~cpol;
							mosi_lvl = shifter[31];
						end
					end
				end
			end
			if (!xfer_on) sck_lvl = cpol;
			due.sck       = sck_lvl;
			due.mosi      = mosi_lvl;
			due.cs_active = cs_lvl;
			due.busy_res  = xfer_on;
			pins_due.push_back(due);
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task check_field(string name, logic [31:0] got_v, logic [31:0] due_v);
			if (got_v !== due_v)
				report($sformatf("result %0d %s: got %h, want %h", n_checked, name, got_v, due_v));
		endtask

		task check_pins(result_t got);
			result_t due;
			if (pins_due.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", n_checked));
			end else begin
				due = pins_due.pop_front();
				check_field("sck", 32'(got.sck), 32'(due.sck));
				check_field("mosi", 32'(got.mosi), 32'(due.mosi));
				check_field("cs_active", 32'(got.cs_active), 32'(due.cs_active));
				check_field("rx_word", got.rx_word, due.rx_word);
				check_field("rx_valid", 32'(got.rx_valid), 32'(due.rx_valid));
				check_field("busy_res", 32'(got.busy_res), 32'(due.busy_res));
				check_field("rejected", 32'(got.rejected), 32'(due.rejected));
			end
			n_checked++;
		endtask
	endclass

	spi_pin_scoreboard pin_board;
	int src_idle_pct;
	int snk_stall_pct;
	int items_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			pin_board.check_pins(result_t'({sck, mosi, cs_active, rx_word, rx_valid,
				busy_res, rejected}));
	end

	function automatic item_t mk_item(opcode_t op, logic [31:0] tx, logic sel, logic rel,
			logic miso_lvl);
		item_t it;
		it.opcode        = op;
		it.tx_word       = tx;
		it.select_before = sel;
		it.release_after = rel;
		it.miso          = miso_lvl;
		return it;
	endfunction

	function automatic item_t rand_item(opcode_t op);
		return mk_item(op, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		opcode        <= it.opcode;
		tx_word       <= it.tx_word;
		select_before <= it.select_before;
		release_after <= it.release_after;
		miso          <= it.miso;
		do @(posedge clk); while (!in_ready);
		pin_board.accept_item(it);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pin_board.pins_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pin_board.write_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_cfg(int half, bit pol, bit pha, int wbits);
		wait_drained();
		apb_write(REG_HALF_PERIOD, half);
		apb_write(REG_CLOCK_POL, 32'(pol));
		apb_write(REG_CLOCK_PHASE, 32'(pha));
		apb_write(REG_WORD_BITS, wbits);
	endtask

	// start a word, then tick until it completes; stray starts land as rejects
	task automatic run_word();
		send_item(rand_item(OP_START));
		while (pin_board.xfer_on)
			send_item(rand_item(($urandom_range(15) == 0) ? OP_START : OP_TICK));
	endtask

	initial begin
		int src_pct[4];
		int snk_pct[4];
		int half_set[8];
		int wbits_set[8];
		int s;
		int base;
		bit paused;

		src_pct   = '{0, 47, 0, 21};
		snk_pct   = '{0, 0, 47, 21};
		half_set  = '{1, 0, 3, 2, 1, 0, 2, 1};
		wbits_set = '{5, 63, 1, 0, 32, 12, 7, 3};

		pin_board     = new();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		items_sent    = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = OP_TICK;
		tx_word       = '0;
		select_before = 1'b0;
		release_after = 1'b0;
		miso          = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// idle tick with every field high
		send_item(mk_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));

		// zero half period and zero word length, mode 3, start while busy
		set_cfg(0, 1, 1, 0);
		send_item(mk_item(OP_START, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
		send_item(mk_item(OP_START, 32'h0, 1'b0, 1'b1, 1'b1));
		send_item(mk_item(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b1));
		send_item(mk_item(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b1));
		send_item(mk_item(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b0));

		// mode 0, two-bit word of zeros, chip select released at the end
		set_cfg(2, 0, 0, 2);
		send_item(mk_item(OP_START, 32'h0, 1'b0, 1'b1, 1'b0));
		for (int i = 0; i < 8; i++)
			send_item(mk_item(OP_TICK, 32'h0, 1'b0, 1'b0, i[1]));

		for (int p = 0; p < 4; p++) begin
			for (int k = 0; k < 2; k++) begin
				s = 2 * p + k;
				set_cfg(half_set[s], s[0], s[1], wbits_set[s]);
				src_idle_pct  = src_pct[p];
				snk_stall_pct = snk_pct[p];
				base   = items_sent;
				paused = 0;
				while (items_sent - base < 48) begin
					if (!paused && items_sent - base >= 24) begin
						wait_drained();
						paused = 1;
					end
					if ($urandom_range(99) < 80)
						run_word();
					else
						send_item(rand_item(opcode_t'($urandom_range(1))));
				end
			end
		end

		// longest half period, single-bit word: the clock holds through a run of ticks
		set_cfg(16'hFFFF, 1, 0, 1);
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		send_item(mk_item(OP_START, $urandom, 1'b1, 1'b1, 1'b0));
		repeat (20)
			send_item(rand_item(OP_TICK));

		wait_drained();
		repeat (8) @(posedge clk);
		if (pin_board.pins_due.size() != 0)
			pin_board.report($sformatf("%0d results never arrived", pin_board.pins_due.size()));
		if (pin_board.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
